// ===== rtl/u8d_pkg.sv =====
// u8d_pkg: shared types, constants and byte classification for the UTF-8 decoder.
// No dependencies; used by every module of the decoder.
`timescale 1ns / 1ps

package u8d_pkg;

  localparam int unsigned FifoDepthDefault = 4;

  localparam logic [7:0]  AsciiLimit = 8'h80;
  localparam logic [7:0]  Lead2Mask  = 8'hE0;
  localparam logic [7:0]  Lead2Code  = 8'hC0;
  localparam logic [7:0]  Lead3Mask  = 8'hF0;
  localparam logic [7:0]  Lead3Code  = 8'hE0;
  localparam logic [7:0]  Lead4Mask  = 8'hF8;
  localparam logic [7:0]  Lead4Code  = 8'hF0;
  localparam logic [20:0] QmarkCp    = 21'h00003F;

  // One decode job: up to four bytes, index of the last one, end-of-string mark.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            last;
  } job_t;

  // Number of continuation bytes a lead byte asks for; 0 for ASCII and invalid.
  function automatic logic [1:0] seq_extra(input logic [7:0] b);
    logic [1:0] r;
    r = 2'd0;
    if ((b & Lead2Mask) == Lead2Code)      r = 2'd1;
    else if ((b & Lead3Mask) == Lead3Code) r = 2'd2;
    else if ((b & Lead4Mask) == Lead4Code) r = 2'd3;
    return r;
  endfunction

endpackage

// ===== rtl/u8d_front.sv =====
// u8d_front: accepts bytes, gathers multi-byte sequences and queues decode jobs.
// Depends on u8d_pkg.
`timescale 1ns / 1ps

module u8d_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    byte_in_i,
  input  logic          end_of_string_i,
  input  logic          fifo_full_i,
  output logic          push_o,
  output u8d_pkg::job_t job_o
);
  import u8d_pkg::*;

  logic [1:0] need_q, need_d;
  logic [1:0] cnt_q, cnt_d;
  logic [2:0][7:0] held_q;
  logic       accept;
  logic       hold_wr;
  logic [1:0] extra;

  assign in_stall_o = fifo_full_i;
  assign accept     = in_valid_i & ~fifo_full_i;
  assign extra      = seq_extra(byte_in_i);

  // Job is always the held bytes followed by the new byte.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (k < 3 && 2'(k) < cnt_q) job_o.bytes[k] = held_q[k];
      else                        job_o.bytes[k] = byte_in_i;
    end
    job_o.last_idx = cnt_q;
    job_o.last     = end_of_string_i;
  end

  always_comb begin
    need_d  = need_q;
    cnt_d   = cnt_q;
    push_o  = 1'b0;
    hold_wr = 1'b0;
    if (accept) begin
      if (end_of_string_i || need_q == 2'd1) begin
        push_o = 1'b1;
        need_d = 2'd0;
        cnt_d  = 2'd0;
      end else if (need_q == 2'd0) begin
        if (extra == 2'd0) begin
          push_o = 1'b1;
        end else begin
          hold_wr = 1'b1;
          need_d  = extra;
          cnt_d   = 2'd1;
        end
      end else begin
        hold_wr = (cnt_q != 2'd3);
        if (cnt_q != 2'd3) cnt_d = cnt_q + 2'd1;
        need_d = need_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_q <= 2'd0;
      cnt_q  <= 2'd0;
    end else begin
      need_q <= need_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_wr) begin
      held_q[cnt_q] <= byte_in_i;
    end
  end

endmodule

// ===== rtl/u8d_fifo.sv =====
// u8d_fifo: small register queue of decode jobs between front and back.
// Depends on u8d_pkg.
`timescale 1ns / 1ps

module u8d_fifo #(
  parameter int unsigned Depth = u8d_pkg::FifoDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  u8d_pkg::job_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output u8d_pkg::job_t rdata_o
);
  import u8d_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrMax) ? '0 : wr_q + PtrW'(1);
      if (do_pop)  rd_q <= (rd_q == PtrMax) ? '0 : rd_q + PtrW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/u8d_back.sv =====
// u8d_back: walks a queued job into the output register, one code point per cycle unless the output stalls.
// Depends on u8d_pkg.
`timescale 1ns / 1ps

module u8d_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  u8d_pkg::job_t job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [20:0]   code_point_o,
  output logic          last_of_string_o
);
  import u8d_pkg::*;

  logic [1:0]  off_q, off_d;
  logic        out_valid_q, out_valid_d;
  logic [20:0] cp_q, cp_d;
  logic        last_q, last_d;
  logic        load;
  logic [7:0]  lead, b1, b2, b3;
  logic [1:0]  extra, step;
  logic [2:0]  end_idx;
  logic        fits, done;

  assign load  = job_valid_i & (~out_valid_q | ~out_stall_i);
  assign lead  = job_i.bytes[off_q];
  assign b1    = job_i.bytes[off_q + 2'd1];
  assign b2    = job_i.bytes[off_q + 2'd2];
  assign b3    = job_i.bytes[off_q + 2'd3];
  assign extra = seq_extra(lead);
  assign fits  = ({1'b0, off_q} + {1'b0, extra}) <= {1'b0, job_i.last_idx};

  always_comb begin
    step = 2'd0;
    cp_d = cp_q;
    if (extra != 2'd0 && fits) begin
      step = extra;
      case (extra)
        2'd1:    cp_d = {10'd0, lead[4:0], b1[5:0]};
        2'd2:    cp_d = {5'd0, lead[3:0], b1[5:0], b2[5:0]};
        2'd3:    cp_d = {lead[2:0], b1[5:0], b2[5:0], b3[5:0]};
        default: cp_d = QmarkCp;
      endcase
    end else if (lead < AsciiLimit) begin
      cp_d = {13'd0, lead};
    end else begin
      cp_d = QmarkCp;
    end
  end

  assign end_idx = {1'b0, off_q} + {1'b0, step};
  assign done    = (end_idx[1:0] == job_i.last_idx);
  assign pop_o   = load & done;
  assign last_d  = job_i.last & done;

  always_comb begin
    off_d       = off_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      off_d       = done ? 2'd0 : end_idx[1:0] + 2'd1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      off_q       <= off_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cp_q   <= cp_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign code_point_o     = cp_q;
  assign last_of_string_o = last_q;

endmodule

// ===== rtl/utf8_to_codepoint_decoder.sv =====
// utf8_to_codepoint_decoder: top level of the lenient UTF-8 to code point decoder.
// Depends on u8d_pkg, u8d_front, u8d_fifo and u8d_back.
//
// Input channel: one byte per word (byte_in_i) with end_of_string_i on the
// final byte of a string; taken when in_valid_i is high and in_stall_o low.
// Output channel: one 21-bit code point per word with last_of_string_o on the
// final code point; taken when out_valid_o is high and out_stall_i low.
// The front gathers lead and continuation bytes and hands complete jobs to a
// FIFO_DEPTH-entry job queue; the back decodes one code point per cycle unless
// the output stalls. Throughput: one byte per cycle at the input unless the
// queue is full. A byte that completes a sequence reaches the back's output
// register through the job queue. A string that ends inside a sequence is
// re-decoded in the back and yields up to 3 code points, one per cycle unless
// the output stalls; the queue absorbs this, and in_stall_o rises only when
// the queue is full. When the receiver stalls, the output word holds and the
// queue fills; the input stalls once FIFO_DEPTH jobs are waiting.
// Reset clears the open sequence, the queue and the output valid at once.
`timescale 1ns / 1ps

module utf8_to_codepoint_decoder #(
  parameter int unsigned FIFO_DEPTH = u8d_pkg::FifoDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  input  logic        end_of_string_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [20:0] code_point_o,
  output logic        last_of_string_o
);
  import u8d_pkg::*;

  logic push, full, job_valid, pop;
  job_t wjob, rjob;

  // Front: sequence gathering, one byte per cycle unless the queue is full.
  u8d_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .byte_in_i       (byte_in_i),
    .end_of_string_i (end_of_string_i),
    .fifo_full_i     (full),
    .push_o          (push),
    .job_o           (wjob)
  );

  // Job queue decouples byte intake from code point output.
  u8d_fifo #(
    .Depth (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wjob),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .rdata_o (rjob)
  );

  // Back: decode and output register.
  u8d_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_valid_i      (job_valid),
    .job_i            (rjob),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .code_point_o     (code_point_o),
    .last_of_string_o (last_of_string_o)
  );

endmodule
